// File: design/lqm_pkg.sv
`default_nettype none

package lqm_pkg;

  // Widths of the item fields on the ports.
  localparam int KIND_W = 2;
  localparam int QID_W  = 2;
  localparam int SLOT_W = 4;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd2;

endpackage

`default_nettype wire

// File: design/linked_queue_manager_unit.sv
`default_nettype none

// A push, or an operation that changes nothing, reads only the queue's head/tail entry
// before its result is registered; a dequeue of a non-empty queue or a remove of a real
// slot then also reads the link entry of the slot taken out, which depends on the first read.
// A new item is taken only once the last one has finished, and a stalled output keeps the
// block busy.
// Reset empties every queue at once through per-queue valid bits; slot links need no clearing.
module linked_queue_manager_unit #(
  parameter int NUM_SLOTS  = 16,
  parameter int NUM_QUEUES = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [lqm_pkg::KIND_W-1:0]  kind,
  input  wire logic [lqm_pkg::QID_W-1:0]   queue_id,
  input  wire logic [lqm_pkg::SLOT_W-1:0]  slot,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [lqm_pkg::SLOT_W-1:0]  slot_out,
  output logic                             slot_out_valid,
  output logic                             queue_empty,
  output logic                             error
);

  localparam int LW = $clog2(NUM_SLOTS + 1);
  localparam int AW = $clog2(NUM_SLOTS + NUM_QUEUES);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [LW-1:0] NONE      = LW'(NUM_SLOTS);
  localparam logic [AW-1:0] SENT_BASE = AW'(NUM_SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HEAD = 2'd1;
  localparam logic [1:0] ST_LINK = 2'd2;

  // Both RAMs hold one entry per slot, then one per queue: the queue entry of the next RAM
  // is the queue's head and that of the prev RAM its tail.
  function automatic logic [LW-1:0] lnk_clamp(input logic [LW-1:0] v);
    lnk_clamp = (v > NONE) ? NONE : v;
  endfunction

  logic [1:0]                  state;
  logic [lqm_pkg::KIND_W-1:0]  op_kind;
  logic                        op_q_ok;
  logic [QW-1:0]               op_queue;
  logic [LW-1:0]               op_slot;
  logic                        op_slot_real;
  logic [LW-1:0]               head;
  logic [LW-1:0]               tail;
  logic                        pend;
  logic [AW-1:0]               pend_addr;
  logic [LW-1:0]               pend_pdata;
  logic [NUM_QUEUES-1:0]       head_valid;
  logic [NUM_QUEUES-1:0]       tail_valid;

  logic [LW-1:0] nxt_rdata, prv_rdata;
  logic          nxt_we, prv_we, rd_en;
  logic [AW-1:0] nxt_waddr, prv_waddr, rd_addr;
  logic [LW-1:0] nxt_wdata, prv_wdata;

  logic          in_accept, out_free, finish;
  logic          q_ok_in, s_real_in;
  logic [AW-1:0] sent;
  logic [LW-1:0] head_rd, tail_rd, cur_head, cur_tail, nx, pv;
  logic          head_none;
  logic          need_link;
  logic          w1n_en, w1n_sent, w1p_en, w1p_sent;
  logic [AW-1:0] w1n_addr, w1p_addr;
  logic [LW-1:0] w1n_data, w1p_data;
  logic          pend_set;
  logic [AW-1:0] pend_addr_new;
  logic [LW-1:0] pend_pdata_new;
  logic [LW-1:0] res, new_head;
  logic          err;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign q_ok_in   = (32'(queue_id) < NUM_QUEUES);
  assign s_real_in = (32'(slot) < NUM_SLOTS);
  assign sent      = SENT_BASE + AW'(op_queue);

  always_comb begin
    head_rd  = head_valid[op_queue] ? lnk_clamp(nxt_rdata) : NONE;
    tail_rd  = tail_valid[op_queue] ? lnk_clamp(prv_rdata) : NONE;
    cur_head = (state == ST_HEAD) ? head_rd : head;
    cur_tail = (state == ST_HEAD) ? tail_rd : tail;
    nx       = lnk_clamp(nxt_rdata);
    pv       = lnk_clamp(prv_rdata);
    head_none = (cur_head == NONE);

    need_link      = 1'b0;
    w1n_en         = 1'b0;
    w1n_sent       = 1'b0;
    w1n_addr       = sent;
    w1n_data       = NONE;
    w1p_en         = 1'b0;
    w1p_sent       = 1'b0;
    w1p_addr       = sent;
    w1p_data       = NONE;
    pend_set       = 1'b0;
    pend_addr_new  = AW'(op_slot);
    pend_pdata_new = NONE;
    res            = NONE;
    err            = 1'b0;
    new_head       = cur_head;

    if (op_q_ok) begin
      case (op_kind)
        lqm_pkg::KIND_PUSH: begin
          if (op_slot_real) begin
            if (head_none) begin
              w1n_en   = 1'b1;
              w1n_sent = 1'b1;
              new_head = op_slot;
            end else begin
              w1n_en         = (cur_tail != NONE);
              w1n_addr       = AW'(cur_tail);
              pend_pdata_new = cur_tail;
            end
            w1n_data = op_slot;
            w1p_en   = 1'b1;
            w1p_sent = 1'b1;
            w1p_data = op_slot;
            pend_set = 1'b1;
          end
        end
        lqm_pkg::KIND_DEQUEUE: begin
          if (head_none) begin
            err = 1'b1;
          end else begin
            need_link = 1'b1;
            w1n_en    = 1'b1;
            w1n_sent  = 1'b1;
            w1n_data  = nx;
            w1p_en    = 1'b1;
            if (nx == NONE) begin
              w1p_sent = 1'b1;
            end else begin
              w1p_addr = AW'(nx);
            end
            pend_set      = 1'b1;
            pend_addr_new = AW'(cur_head);
            res           = cur_head;
            new_head      = nx;
          end
        end
        lqm_pkg::KIND_REMOVE: begin
          if (op_slot_real) begin
            need_link = 1'b1;
            if (op_slot == cur_head && op_slot == cur_tail) begin
              w1n_en   = 1'b1;
              w1n_sent = 1'b1;
              w1p_en   = 1'b1;
              w1p_sent = 1'b1;
              new_head = NONE;
            end else if (op_slot == cur_head) begin
              w1n_en   = 1'b1;
              w1n_sent = 1'b1;
              w1n_data = nx;
              w1p_en   = (nx != NONE);
              w1p_addr = AW'(nx);
              new_head = nx;
            end else if (op_slot == cur_tail) begin
              w1n_en   = (pv != NONE);
              w1n_addr = AW'(pv);
              w1p_en   = 1'b1;
              w1p_sent = 1'b1;
              w1p_data = pv;
            end else begin
              w1n_en   = (pv != NONE);
              w1n_addr = AW'(pv);
              w1n_data = nx;
              w1p_en   = (nx != NONE);
              w1p_addr = AW'(nx);
              w1p_data = pv;
            end
            pend_set = 1'b1;
            res      = nx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (state)
      ST_HEAD: finish = !need_link && out_free;
      ST_LINK: finish = out_free;
      default: finish = 1'b0;
    endcase
  end

  // The second write of an operation always lands on a slot entry, so it is safely
  // deferred to the idle cycle, where the only read is of a queue entry.
  always_comb begin
    if (state == ST_IDLE) begin
      nxt_we    = pend;
      prv_we    = pend;
      nxt_waddr = pend_addr;
      prv_waddr = pend_addr;
      nxt_wdata = NONE;
      prv_wdata = pend_pdata;
    end else begin
      nxt_we    = finish && w1n_en;
      prv_we    = finish && w1p_en;
      nxt_waddr = w1n_addr;
      prv_waddr = w1p_addr;
      nxt_wdata = w1n_data;
      prv_wdata = w1p_data;
    end
  end

  always_comb begin
    if (state == ST_IDLE) begin
      rd_en   = in_accept && q_ok_in;
      rd_addr = SENT_BASE + AW'(QW'(queue_id));
    end else begin
      rd_en   = (state == ST_HEAD) && need_link;
      rd_addr = (op_kind == lqm_pkg::KIND_REMOVE) ? AW'(op_slot) : AW'(cur_head);
    end
  end

  lqm_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_SLOTS + NUM_QUEUES)
  ) u_next_ram (
    .clk     (clk),
    .wr_en   (nxt_we),
    .wr_addr (nxt_waddr),
    .wr_data (nxt_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (nxt_rdata)
  );

  lqm_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_SLOTS + NUM_QUEUES)
  ) u_prev_ram (
    .clk     (clk),
    .wr_en   (prv_we),
    .wr_addr (prv_waddr),
    .wr_data (prv_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (prv_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend       <= 1'b0;
      head_valid <= '0;
      tail_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          pend <= 1'b0;
          if (in_accept) begin
            state <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          if (need_link) begin
            state <= ST_LINK;
          end else if (finish) begin
            state <= ST_IDLE;
          end
        end
        ST_LINK: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (finish) begin
        pend <= pend_set;
        if (w1n_en && w1n_sent) begin
          head_valid[op_queue] <= 1'b1;
        end
        if (w1p_en && w1p_sent) begin
          tail_valid[op_queue] <= 1'b1;
        end
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_kind      <= kind;
      op_q_ok      <= q_ok_in;
      op_queue     <= QW'(queue_id);
      op_slot      <= LW'(slot);
      op_slot_real <= s_real_in;
    end
    if (state == ST_HEAD) begin
      head <= head_rd;
      tail <= tail_rd;
    end
    if (finish) begin
      pend_addr      <= pend_addr_new;
      pend_pdata     <= pend_pdata_new;
      slot_out       <= (res != NONE) ? lqm_pkg::SLOT_W'(res) : '0;
      slot_out_valid <= (res != NONE);
      queue_empty    <= op_q_ok ? (new_head == NONE) : 1'b1;
      error          <= err;
    end
  end

`ifndef SYNTH
  a_pend_only_idle: assert property (@(posedge clk) disable iff (rst)
    pend |-> state == ST_IDLE)
    else $error("deferred link write outstanding outside the idle state");

  a_pend_real_slot: assert property (@(posedge clk) disable iff (rst)
    pend |-> 32'(pend_addr) < NUM_SLOTS)
    else $error("deferred link write aimed at a queue entry");

  a_link_after_head: assert property (@(posedge clk) disable iff (rst)
    state == ST_LINK |-> $past(state) == ST_HEAD || $past(state) == ST_LINK)
    else $error("link stage entered without a head read");

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> queue_empty && !slot_out_valid)
    else $error("error beat reports a slot or a non-empty queue");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_HEAD)
    else $error("accepted beat did not start a head read");
`endif

endmodule

`default_nettype wire

// File: design/lqm_ram.sv
`default_nettype none

module lqm_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: dv/lqm_checker.sv
`timescale 1ns / 100ps

module lqm_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic [lqm_pkg::KIND_W-1:0] kind,
  input  wire logic [lqm_pkg::QID_W-1:0]  queue_id,
  input  wire logic [lqm_pkg::SLOT_W-1:0] slot,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [lqm_pkg::SLOT_W-1:0] slot_out,
  input  wire logic                       slot_out_valid,
  input  wire logic                       queue_empty,
  input  wire logic                       error,
  output int                              mismatches,
  output int                              pending
);

  localparam int NSLOTS  = 16;
  localparam int NQUEUES = 4;
  localparam logic [4:0] NO_SLOT = 5'd16;

  typedef struct packed {
    logic [lqm_pkg::SLOT_W-1:0] slot_out;
    logic                       slot_out_valid;
    logic                       queue_empty;
    logic                       error;
  } queue_result_t;

  logic [4:0] head_q [NQUEUES];
  logic [4:0] tail_q [NQUEUES];
  logic [4:0] next_q [NSLOTS];
  logic [4:0] prev_q [NSLOTS];

  queue_result_t results_due [$];

  // A link that points at the none position reads as none, and writes there are dropped.
  function automatic logic [4:0] next_of(logic [4:0] s);
    if (s >= NO_SLOT) return NO_SLOT;
    return (next_q[s[3:0]] > NO_SLOT) ? NO_SLOT : next_q[s[3:0]];
  endfunction

  function automatic logic [4:0] prev_of(logic [4:0] s);
    if (s >= NO_SLOT) return NO_SLOT;
    return (prev_q[s[3:0]] > NO_SLOT) ? NO_SLOT : prev_q[s[3:0]];
  endfunction

  function automatic void set_next(logic [4:0] s, logic [4:0] v);
    if (s < NO_SLOT) next_q[s[3:0]] = v;
  endfunction

  function automatic void set_prev(logic [4:0] s, logic [4:0] v);
    if (s < NO_SLOT) prev_q[s[3:0]] = v;
  endfunction

  function automatic queue_result_t apply_queue_op(logic [lqm_pkg::KIND_W-1:0] k,
                                                   logic [lqm_pkg::QID_W-1:0] q,
                                                   logic [lqm_pkg::SLOT_W-1:0] s_in);
    logic [4:0] s;
    logic [4:0] h;
    logic [4:0] t;
    logic [4:0] nx;
    logic [4:0] pv;
    logic [4:0] res;
    queue_result_t r;
    s = {1'b0, s_in};
    h = head_q[q];
    t = tail_q[q];
    res = NO_SLOT;
    r.error = 1'b0;
    if (k == lqm_pkg::KIND_PUSH) begin
      if (h == NO_SLOT) begin
        head_q[q] = s;
        tail_q[q] = s;
        set_next(s, NO_SLOT);
        set_prev(s, NO_SLOT);
      end else begin
        set_next(t, s);
        set_next(s, NO_SLOT);
        set_prev(s, t);
        tail_q[q] = s;
      end
    end else if (k == lqm_pkg::KIND_DEQUEUE) begin
      if (h == NO_SLOT) begin
        r.error = 1'b1;
      end else begin
        nx = next_of(h);
        if (nx == NO_SLOT) begin
          head_q[q] = NO_SLOT;
          tail_q[q] = NO_SLOT;
        end else begin
          head_q[q] = nx;
          set_prev(nx, NO_SLOT);
        end
        set_next(h, NO_SLOT);
        set_prev(h, NO_SLOT);
        res = h;
      end
    end else if (k == lqm_pkg::KIND_REMOVE) begin
      nx = next_of(s);
      pv = prev_of(s);
      if (s == h && s == t) begin
        head_q[q] = NO_SLOT;
        tail_q[q] = NO_SLOT;
      end else if (s == h) begin
        head_q[q] = nx;
        set_prev(nx, NO_SLOT);
      end else if (s == t) begin
        tail_q[q] = pv;
        set_next(pv, NO_SLOT);
      end else begin
        set_next(pv, nx);
        set_prev(nx, pv);
      end
      set_next(s, NO_SLOT);
      set_prev(s, NO_SLOT);
      res = nx;
    end
    r.slot_out_valid = (res < NO_SLOT);
    r.slot_out       = (res < NO_SLOT) ? res[3:0] : '0;
    r.queue_empty    = (head_q[q] == NO_SLOT);
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      for (int i = 0; i < NQUEUES; i++) begin
        head_q[i] = NO_SLOT;
        tail_q[i] = NO_SLOT;
      end
      for (int i = 0; i < NSLOTS; i++) begin
        next_q[i] = '0;
        prev_q[i] = '0;
      end
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (want.slot_out !== slot_out) begin
            $error("slot_out: expected %0d, actual %0d", want.slot_out, slot_out);
            mismatches++;
          end
          if (want.slot_out_valid !== slot_out_valid) begin
            $error("slot_out_valid: expected %0d, actual %0d", want.slot_out_valid,
                   slot_out_valid);
            mismatches++;
          end
          if (want.queue_empty !== queue_empty) begin
            $error("queue_empty: expected %0d, actual %0d", want.queue_empty, queue_empty);
            mismatches++;
          end
          if (want.error !== error) begin
            $error("error: expected %0d, actual %0d", want.error, error);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        results_due.push_back(apply_queue_op(kind, queue_id, slot));
      end
    end
    pending = results_due.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic [lqm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int STALL_LIMIT     = 1000;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [lqm_pkg::KIND_W-1:0] kind;
  logic [lqm_pkg::QID_W-1:0]  queue_id;
  logic [lqm_pkg::SLOT_W-1:0] slot;
  logic                       out_valid;
  logic                       out_stall;
  logic [lqm_pkg::SLOT_W-1:0] slot_out;
  logic                       slot_out_valid;
  logic                       queue_empty;
  logic                       error;

  int mismatches;
  int pending;

  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  // Rough picture of queue membership, used only to steer the stimulus.
  int owner [16];
  int order [16];
  bit pushed_ever [16];
  int order_count;
  int n_push, n_deq, n_rem, n_other;

  linked_queue_manager_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .queue_id(queue_id), .slot(slot),
    .out_valid(out_valid), .out_stall(out_stall),
    .slot_out(slot_out), .slot_out_valid(slot_out_valid),
    .queue_empty(queue_empty), .error(error)
  );

  lqm_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .queue_id(queue_id), .slot(slot),
    .out_valid(out_valid), .out_stall(out_stall),
    .slot_out(slot_out), .slot_out_valid(slot_out_valid),
    .queue_empty(queue_empty), .error(error),
    .mismatches(mismatches), .pending(pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: watchdog expired with %0d results outstanding", pending);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Mode 0: free slots, 1: slots in queue q, 2: slots ever pushed, 3: slots in any queue.
  function automatic int pick_slot(int mode, int q);
    int cand [16];
    int n;
    bit ok;
    n = 0;
    for (int i = 0; i < 16; i++) begin
      case (mode)
        0: ok = (owner[i] < 0);
        1: ok = (owner[i] == q);
        2: ok = pushed_ever[i];
        default: ok = (owner[i] >= 0);
      endcase
      if (ok) begin
        cand[n] = i;
        n++;
      end
    end
    if (n == 0) return -1;
    return cand[$urandom_range(0, n - 1)];
  endfunction

  function automatic int head_of(int q);
    int best;
    best = -1;
    for (int i = 0; i < 16; i++) begin
      if (owner[i] == q && (best < 0 || order[i] < order[best])) best = i;
    end
    return best;
  endfunction

  // One beat on the input channel; valid stays up until the block takes it.
  task automatic issue(input logic [lqm_pkg::KIND_W-1:0] k, input int q, input int s);
    int h;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind     = k;
    queue_id = lqm_pkg::QID_W'(q);
    slot     = lqm_pkg::SLOT_W'(s);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (k)
      lqm_pkg::KIND_PUSH: begin
        n_push++;
        pushed_ever[s] = 1'b1;
        if (owner[s] < 0) begin
          owner[s] = q;
          order[s] = order_count;
          order_count++;
        end
      end
      lqm_pkg::KIND_DEQUEUE: begin
        n_deq++;
        h = head_of(q);
        if (h >= 0) owner[h] = -1;
      end
      lqm_pkg::KIND_REMOVE: begin
        n_rem++;
        owner[s] = -1;
      end
      default: n_other++;
    endcase
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_step(int push_pct);
    int r;
    int q;
    int s;
    r = $urandom_range(0, 99);
    q = $urandom_range(0, 3);
    if (r < 8) begin
      // Noise: unused kind, dequeue of an empty queue, duplicate push, foreign remove.
      case ($urandom_range(0, 3))
        0: issue(KIND_UNUSED, q, $urandom_range(0, 15));
        1: begin
          for (int i = 0; i < 4; i++) begin
            if (head_of((q + i) % 4) < 0) begin
              q = (q + i) % 4;
              break;
            end
          end
          issue(lqm_pkg::KIND_DEQUEUE, q, $urandom_range(0, 15));
        end
        2: begin
          s = pick_slot(3, 0);
          if (s < 0) issue(KIND_UNUSED, q, $urandom_range(0, 15));
          else issue(lqm_pkg::KIND_PUSH, q, s);
        end
        default: begin
          s = pick_slot(2, 0);
          if (s < 0) issue(KIND_UNUSED, q, $urandom_range(0, 15));
          else issue(lqm_pkg::KIND_REMOVE, q, s);
        end
      endcase
    end else begin
      r = $urandom_range(0, 99);
      s = pick_slot(0, 0);
      if (s >= 0 && (r < push_pct || pick_slot(3, 0) < 0)) begin
        issue(lqm_pkg::KIND_PUSH, q, s);
      end else if (r < push_pct + (100 - push_pct) / 2) begin
        s = pick_slot(3, 0);
        if (s >= 0) q = owner[s];
        issue(lqm_pkg::KIND_DEQUEUE, q, $urandom_range(0, 15));
      end else begin
        s = pick_slot(3, 0);
        issue(lqm_pkg::KIND_REMOVE, owner[s], s);
      end
    end
  endtask

  task automatic directed_items();
    issue(lqm_pkg::KIND_DEQUEUE, 0, 9);
    issue(lqm_pkg::KIND_PUSH,    0, 0);
    issue(lqm_pkg::KIND_PUSH,    0, 15);
    issue(lqm_pkg::KIND_PUSH,    0, 5);
    // Middle remove relinks the neighbours of the removed slot.
    issue(lqm_pkg::KIND_REMOVE,  0, 15);
    issue(lqm_pkg::KIND_REMOVE,  0, 5);
    issue(lqm_pkg::KIND_PUSH,    3, 15);
    issue(lqm_pkg::KIND_REMOVE,  0, 0);
    issue(KIND_UNUSED,           3, 15);
    issue(KIND_UNUSED,           0, 0);
    issue(lqm_pkg::KIND_PUSH,    1, 10);
    issue(lqm_pkg::KIND_PUSH,    1, 11);
    issue(lqm_pkg::KIND_REMOVE,  1, 10);
    issue(lqm_pkg::KIND_DEQUEUE, 1, 0);
    issue(lqm_pkg::KIND_DEQUEUE, 3, 15);
    issue(lqm_pkg::KIND_DEQUEUE, 3, 15);
    // Duplicate and foreign slots go through the same link writes unchecked.
    issue(lqm_pkg::KIND_PUSH,    2, 7);
    issue(lqm_pkg::KIND_PUSH,    2, 7);
    issue(lqm_pkg::KIND_PUSH,    1, 7);
    issue(lqm_pkg::KIND_REMOVE,  3, 7);
    issue(lqm_pkg::KIND_DEQUEUE, 2, 3);
    issue(lqm_pkg::KIND_DEQUEUE, 1, 12);
  endtask

  initial begin
    int push_pct;
    rst            = 1'b1;
    in_valid       = 1'b0;
    kind           = '0;
    queue_id       = '0;
    slot           = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    order_count    = 0;
    n_push = 0; n_deq = 0; n_rem = 0; n_other = 0;
    for (int i = 0; i < 16; i++) begin
      owner[i]       = -1;
      order[i]       = 0;
      pushed_ever[i] = 1'b0;
    end
    repeat (8) @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 19; recv_stall_pct = 48; end
        1: begin send_idle_pct = 48; recv_stall_pct = 19; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 0) directed_items();
      push_pct = 50;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Vary the push share so the pool sometimes fills and sometimes runs dry.
        if (n % 60 == 0) push_pct = $urandom_range(20, 75);
        if (n == ITEMS_PER_PHASE / 2) drain_results();
        random_step(push_pct);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("tb: %0d operations sent: %0d push, %0d dequeue, %0d remove, %0d unused kind",
             n_push + n_deq + n_rem + n_other, n_push, n_deq, n_rem, n_other);
    $display("tb: three idle patterns on the two channels, each with a pause until drained");
    if (mismatches == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
design/lqm_pkg.sv
design/lqm_ram.sv
design/linked_queue_manager_unit.sv
dv/lqm_checker.sv
dv/tb.sv
